@@ hdl/tcpcl_pkg.sv @@
// Shared types, codes and per-phase tables of the TCPCLv4 message parser.
package tcpcl_pkg;

  // Parse phases, one per field position in the contact header or a message
  typedef enum logic [4:0] {
    PH_MAGIC,
    PH_VERSION,
    PH_CFLAGS,
    PH_TYPE,
    PH_SEG_FLAGS,
    PH_SEG_TID,
    PH_SEG_EXTLEN,
    PH_SEG_EXT,
    PH_SEG_DLEN,
    PH_SEG_DATA,
    PH_ACK_FLAGS,
    PH_ACK_TID,
    PH_ACK_LEN,
    PH_REF_REASON,
    PH_REF_TID,
    PH_TERM_FLAGS,
    PH_TERM_REASON,
    PH_REJ_REASON,
    PH_REJ_TYPE,
    PH_SI_KA,
    PH_SI_SMRU,
    PH_SI_TMRU,
    PH_SI_NIDLEN,
    PH_SI_NID,
    PH_SI_EXTLEN,
    PH_SI_EXT
  } phase_e;

  // Field identifiers reported with each result
  localparam logic [4:0] FID_TYPE         = 5'd0;
  localparam logic [4:0] FID_VERSION      = 5'd1;
  localparam logic [4:0] FID_CFLAGS       = 5'd2;
  localparam logic [4:0] FID_MFLAGS       = 5'd3;
  localparam logic [4:0] FID_XFER_ID      = 5'd4;
  localparam logic [4:0] FID_XEXT_LEN     = 5'd5;
  localparam logic [4:0] FID_XEXT_OCTET   = 5'd6;
  localparam logic [4:0] FID_DATA_LEN     = 5'd7;
  localparam logic [4:0] FID_DATA_OCTET   = 5'd8;
  localparam logic [4:0] FID_ACK_LEN      = 5'd9;
  localparam logic [4:0] FID_REFUSE_RSN   = 5'd10;
  localparam logic [4:0] FID_KEEPALIVE    = 5'd11;
  localparam logic [4:0] FID_SEG_MRU      = 5'd12;
  localparam logic [4:0] FID_XFER_MRU     = 5'd13;
  localparam logic [4:0] FID_NODEID_LEN   = 5'd14;
  localparam logic [4:0] FID_NODEID_OCTET = 5'd15;
  localparam logic [4:0] FID_SEXT_LEN     = 5'd16;
  localparam logic [4:0] FID_SEXT_OCTET   = 5'd17;
  localparam logic [4:0] FID_TERM_RSN     = 5'd18;
  localparam logic [4:0] FID_REJECT_RSN   = 5'd19;
  localparam logic [4:0] FID_REJECT_TYPE  = 5'd20;

  // Message kinds (contact header, then the message type codes)
  localparam logic [2:0] KIND_CONTACT   = 3'd0;
  localparam logic [2:0] KIND_SEGMENT   = 3'd1;
  localparam logic [2:0] KIND_ACK       = 3'd2;
  localparam logic [2:0] KIND_REFUSE    = 3'd3;
  localparam logic [2:0] KIND_KEEPALIVE = 3'd4;
  localparam logic [2:0] KIND_TERM      = 3'd5;
  localparam logic [2:0] KIND_REJECT    = 3'd6;
  localparam logic [2:0] KIND_SESSINIT  = 3'd7;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_MAGIC = 2'd1;
  localparam logic [1:0] ERR_TYPE  = 2'd2;

  // Configuration register indexes and reset values
  localparam logic        CFG_MAGIC        = 1'b0;
  localparam logic        CFG_START_MASK   = 1'b1;
  localparam logic [31:0] MAGIC_RESET      = 32'h6474_6E21;
  localparam logic [7:0]  START_MASK_RESET = 8'h02;

  typedef struct packed {
    logic [31:0] magic;
    logic [7:0]  start_mask;
  } cfg_t;

  typedef struct packed {
    logic        vld;
    logic [4:0]  fid;
    logic [63:0] value;
    logic [2:0]  kind;
    logic        eom;
    logic [1:0]  err;
  } result_t;

  // Octets in the field of each phase
  function automatic logic [3:0] phase_width(phase_e ph);
    logic [3:0] w;
    case (ph)
      PH_MAGIC:      w = 4'd4;
      PH_SEG_TID:    w = 4'd8;
      PH_SEG_EXTLEN: w = 4'd4;
      PH_SEG_DLEN:   w = 4'd8;
      PH_ACK_TID:    w = 4'd8;
      PH_ACK_LEN:    w = 4'd8;
      PH_REF_TID:    w = 4'd8;
      PH_SI_KA:      w = 4'd2;
      PH_SI_SMRU:    w = 4'd8;
      PH_SI_TMRU:    w = 4'd8;
      PH_SI_NIDLEN:  w = 4'd2;
      PH_SI_EXTLEN:  w = 4'd4;
      default:       w = 4'd1;
    endcase
    return w;
  endfunction

  // Field identifier reported when the field of each phase completes
  function automatic logic [4:0] phase_field(phase_e ph);
    logic [4:0] f;
    case (ph)
      PH_MAGIC:       f = FID_TYPE;
      PH_VERSION:     f = FID_VERSION;
      PH_CFLAGS:      f = FID_CFLAGS;
      PH_TYPE:        f = FID_TYPE;
      PH_SEG_FLAGS:   f = FID_MFLAGS;
      PH_SEG_TID:     f = FID_XFER_ID;
      PH_SEG_EXTLEN:  f = FID_XEXT_LEN;
      PH_SEG_EXT:     f = FID_XEXT_OCTET;
      PH_SEG_DLEN:    f = FID_DATA_LEN;
      PH_SEG_DATA:    f = FID_DATA_OCTET;
      PH_ACK_FLAGS:   f = FID_MFLAGS;
      PH_ACK_TID:     f = FID_XFER_ID;
      PH_ACK_LEN:     f = FID_ACK_LEN;
      PH_REF_REASON:  f = FID_REFUSE_RSN;
      PH_REF_TID:     f = FID_XFER_ID;
      PH_TERM_FLAGS:  f = FID_MFLAGS;
      PH_TERM_REASON: f = FID_TERM_RSN;
      PH_REJ_REASON:  f = FID_REJECT_RSN;
      PH_REJ_TYPE:    f = FID_REJECT_TYPE;
      PH_SI_KA:       f = FID_KEEPALIVE;
      PH_SI_SMRU:     f = FID_SEG_MRU;
      PH_SI_TMRU:     f = FID_XFER_MRU;
      PH_SI_NIDLEN:   f = FID_NODEID_LEN;
      PH_SI_NID:      f = FID_NODEID_OCTET;
      PH_SI_EXTLEN:   f = FID_SEXT_LEN;
      PH_SI_EXT:      f = FID_SEXT_OCTET;
      default:        f = FID_TYPE;
    endcase
    return f;
  endfunction

endpackage

@@ hdl/tcpcl_message_parser_unit.sv @@
// Top level of the TCPCLv4 message parser: stream ports, input and result registers.
// An input octet is held in the input register, its result then in the result register.
// Throughput: one octet per cycle unless the master stalls; the core's phase update sets it.
// An octet that completes no field yields no result transfer.
// Reset clears the parse state to expect the contact magic, loads the magic
// register with "dtn!" and the start flag mask with 0x02, and empties both registers stages.
module tcpcl_message_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] session_restart
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [4:0] field_id, [68:5] field_value, [71:69] msg_kind
  output logic        m_axis_tlast,   // end_of_message
  output logic [1:0]  m_axis_tuser    // [1:0] error_code
);
  import tcpcl_pkg::*;

  cfg_t       cfg;
  result_t    res;
  result_t    out_q;
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_rst_q;
  logic       out_vld_q;
  logic       fire;
  logic       s_take;

  tcpcl_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tcpcl_parse_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (fire),
    .rx_byte_i (in_byte_q),
    .restart_i (in_rst_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // Parse the held octet when the result register is free or draining
  assign fire          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_byte_q <= s_axis_tdata;
      in_rst_q  <= s_axis_tuser;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= res.vld;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.vld) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.kind, out_q.value, out_q.fid};
  assign m_axis_tlast  = out_q.eom;
  assign m_axis_tuser  = out_q.err;

  // An error result always closes its message
  a_err_eom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ERR_NONE |-> m_axis_tlast)
    else $error("error result without end of message");

  // Backpressure on the input only when both stages are full and the output stalls
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && out_vld_q && !m_axis_tready)
    else $error("input stalled with a free stage");

  // A transfer in always fills the input register
  a_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> in_vld_q)
    else $error("accepted octet lost");

endmodule

@@ hdl/tcpcl_cfg_regs.sv @@
// Configuration registers: expected contact magic and segment start flag mask.
module tcpcl_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  output tcpcl_pkg::cfg_t     cfg_o
);
  import tcpcl_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAGIC:      cfg_d.magic      = cfg_data_i;
        CFG_START_MASK: cfg_d.start_mask = cfg_data_i[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic      <= MAGIC_RESET;
      cfg_q.start_mask <= START_MASK_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/tcpcl_parse_core.sv @@
// Parse state and the per-octet phase update with result selection.
module tcpcl_parse_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 restart_i,
  input  tcpcl_pkg::cfg_t      cfg_i,
  output tcpcl_pkg::result_t   res_o
);
  import tcpcl_pkg::*;

  phase_e      phase_q, phase_d, phase_eff;
  logic [2:0]  kind_q, kind_d, kind_eff;
  logic [3:0]  cnt_q, cnt_d, cnt_eff, cnt_inc;
  logic [63:0] acc_q, acc_d, acc_eff, v;
  logic [63:0] rem_q, rem_d, rem_eff, rem_dec;
  logic [7:0]  flags_q, flags_d, flags_eff;
  logic        halted_q, halted_d, halted_eff;
  result_t     res;

  always_comb begin
    // A restart octet sees the cleared state
    phase_eff  = restart_i ? PH_MAGIC     : phase_q;
    kind_eff   = restart_i ? KIND_CONTACT : kind_q;
    cnt_eff    = restart_i ? 4'd0         : cnt_q;
    acc_eff    = restart_i ? 64'd0        : acc_q;
    rem_eff    = restart_i ? 64'd0        : rem_q;
    flags_eff  = restart_i ? 8'd0         : flags_q;
    halted_eff = restart_i ? 1'b0         : halted_q;

    phase_d  = phase_eff;
    kind_d   = kind_eff;
    cnt_d    = cnt_eff;
    acc_d    = acc_eff;
    rem_d    = rem_eff;
    flags_d  = flags_eff;
    halted_d = halted_eff;

    v       = {acc_eff[55:0], rx_byte_i};
    cnt_inc = cnt_eff + 4'd1;
    rem_dec = rem_eff - 64'd1;

    res       = '0;
    res.err   = ERR_NONE;

    if (!halted_eff) begin
      if (cnt_inc < phase_width(phase_eff)) begin
        // Collect another octet of a multi-octet field
        acc_d = v;
        cnt_d = cnt_inc;
      end else begin
        acc_d     = '0;
        cnt_d     = '0;
        res.vld   = 1'b1;
        res.fid   = phase_field(phase_eff);
        res.value = v;
        case (phase_eff)
          PH_MAGIC: begin
            kind_d = KIND_CONTACT;
            if (v[31:0] != cfg_i.magic) begin
              halted_d  = 1'b1;
              res.value = {32'd0, v[31:0]};
              res.eom   = 1'b1;
              res.err   = ERR_MAGIC;
            end else begin
              phase_d = PH_VERSION;
              res.vld = 1'b0;
            end
          end
          PH_VERSION: phase_d = PH_CFLAGS;
          PH_CFLAGS: begin
            phase_d = PH_TYPE;
            res.eom = 1'b1;
          end
          PH_TYPE: begin
            if (v[63:3] != '0 || v[2:0] == KIND_CONTACT) begin
              // Unknown type: report and halt
              kind_d   = KIND_CONTACT;
              halted_d = 1'b1;
              res.eom  = 1'b1;
              res.err  = ERR_TYPE;
            end else begin
              kind_d = v[2:0];
              case (v[2:0])
                KIND_SEGMENT: phase_d = PH_SEG_FLAGS;
                KIND_ACK:     phase_d = PH_ACK_FLAGS;
                KIND_REFUSE:  phase_d = PH_REF_REASON;
                KIND_KEEPALIVE: begin
                  phase_d = PH_TYPE;
                  res.eom = 1'b1;
                end
                KIND_TERM:    phase_d = PH_TERM_FLAGS;
                KIND_REJECT:  phase_d = PH_REJ_REASON;
                default:      phase_d = PH_SI_KA;
              endcase
            end
          end
          PH_SEG_FLAGS: begin
            flags_d = v[7:0];
            phase_d = PH_SEG_TID;
          end
          PH_SEG_TID: begin
            phase_d = ((flags_eff & cfg_i.start_mask) != '0) ? PH_SEG_EXTLEN : PH_SEG_DLEN;
          end
          PH_SEG_EXTLEN: begin
            rem_d   = v;
            phase_d = (v != '0) ? PH_SEG_EXT : PH_SEG_DLEN;
          end
          PH_SEG_EXT: begin
            rem_d = rem_dec;
            if (rem_dec == '0) phase_d = PH_SEG_DLEN;
          end
          PH_SEG_DLEN: begin
            rem_d = v;
            if (v != '0) begin
              phase_d = PH_SEG_DATA;
            end else begin
              phase_d = PH_TYPE;
              res.eom = 1'b1;
            end
          end
          PH_SEG_DATA: begin
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              phase_d = PH_TYPE;
              res.eom = 1'b1;
            end
          end
          PH_ACK_FLAGS:  phase_d = PH_ACK_TID;
          PH_ACK_TID:    phase_d = PH_ACK_LEN;
          PH_REF_REASON: phase_d = PH_REF_TID;
          PH_TERM_FLAGS: phase_d = PH_TERM_REASON;
          PH_REJ_REASON: phase_d = PH_REJ_TYPE;
          PH_SI_KA:      phase_d = PH_SI_SMRU;
          PH_SI_SMRU:    phase_d = PH_SI_TMRU;
          PH_SI_TMRU:    phase_d = PH_SI_NIDLEN;
          PH_SI_NIDLEN: begin
            rem_d   = v;
            phase_d = (v != '0) ? PH_SI_NID : PH_SI_EXTLEN;
          end
          PH_SI_NID: begin
            rem_d = rem_dec;
            if (rem_dec == '0) phase_d = PH_SI_EXTLEN;
          end
          PH_SI_EXTLEN: begin
            rem_d = v;
            if (v != '0) begin
              phase_d = PH_SI_EXT;
            end else begin
              phase_d = PH_TYPE;
              res.eom = 1'b1;
            end
          end
          PH_SI_EXT: begin
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              phase_d = PH_TYPE;
              res.eom = 1'b1;
            end
          end
          default: begin
            // Last field of ack, refuse, term and reject messages
            phase_d = PH_TYPE;
            res.eom = 1'b1;
          end
        endcase
      end
    end
    res.kind = kind_d;
  end

  // Advance the parse state on each octet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC;
      kind_q   <= KIND_CONTACT;
      cnt_q    <= '0;
      acc_q    <= '0;
      rem_q    <= '0;
      flags_q  <= '0;
      halted_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      cnt_q    <= cnt_d;
      acc_q    <= acc_d;
      rem_q    <= rem_d;
      flags_q  <= flags_d;
      halted_q <= halted_d;
    end
  end

  assign res_o = res;

endmodule
